FILE: sv/qeadec_pkg.sv
// ---------------------------------------------------------------------------
// qeadec_pkg
// Types, codes and lookup tables shared by the quadrature decoder modules.
// ---------------------------------------------------------------------------
package qeadec_pkg;

	localparam logic [3:0]  CountCap   = 4'd12;
	localparam logic [3:0]  FastAfter  = 4'd6;
	localparam logic [7:0]  SpeedFast  = 8'd51;
	localparam logic [31:0] DecayMs    = 32'd100;
	localparam logic [31:0] IdleMs     = 32'd500;
	localparam logic [31:0] DetentTimeReset = 32'd500;
	localparam logic [2:0]  TypeMax    = 3'd4;

	localparam logic [1:0] CFG_ENCODER_TYPE = 2'd0;
	localparam logic [1:0] CFG_FAST_LIMIT   = 2'd1;
	localparam logic [1:0] CFG_MAX_POSITION = 2'd2;
	localparam logic [1:0] CFG_DEVICE_ID    = 2'd3;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_UP_SLOW   = 3'd1,
		EV_DOWN_SLOW = 3'd2,
		EV_UP_FAST   = 3'd3,
		EV_DOWN_FAST = 3'd4
	} turn_event_t;

	typedef struct packed {
		logic [2:0]  encoder_type;
		logic [7:0]  fast_limit;
		logic [14:0] max_position;
		logic [7:0]  device_id;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         prev_pins;
		logic signed [15:0] fine_position;
		logic signed [15:0] detent_position;
		logic signed [15:0] reported_position;
		logic [3:0]         detent_count;
		logic [31:0]        last_decay_time;
		logic [31:0]        detent_time;
		logic [31:0]        detent_time_prev;
	} dec_state_t;

	typedef struct packed {
		turn_event_t        turn_event;
		logic [7:0]         event_device;
		logic signed [15:0] position_out;
	} result_t;

	// direction from {previous pins, current pins}
	function automatic logic signed [1:0] dir_lookup(input logic [3:0] idx);
		logic signed [1:0] d;
		case (idx)
			4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
			4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
			default: d = 2'sd0;
		endcase
		return d;
	endfunction

	function automatic logic [3:0] detent_mask(input logic [2:0] enc_type);
		logic [3:0] m;
		case (enc_type)
			3'd0: m = 4'h8;
			3'd1: m = 4'h1;
			3'd2: m = 4'h9;
			3'd3: m = 4'h6;
			default: m = 4'hF;
		endcase
		return m;
	endfunction

	function automatic logic [1:0] res_shift(input logic [2:0] enc_type);
		logic [1:0] s;
		case (enc_type)
			3'd0, 3'd1: s = 2'd2;
			3'd2, 3'd3: s = 2'd1;
			default: s = 2'd0;
		endcase
		return s;
	endfunction

endpackage

FILE: sv/qeadec_step.sv
// ---------------------------------------------------------------------------
// qeadec_step
// Next-state and result logic for one encoder poll: count decay, transition
// decode, acceleration, detent update, event classification, overflow guard.
// ---------------------------------------------------------------------------
module qeadec_step
	import qeadec_pkg::*;
(
	input  cfg_t        cfg,
	input  dec_state_t  cur,
	input  logic        sig_a,
	input  logic        sig_b,
	input  logic [31:0] now_ms,
	output dec_state_t  nxt,
	output result_t     res
);

	logic [2:0]         enc_type;
	logic [1:0]         sh;
	logic [3:0]         dmask;
	logic [1:0]         pins;
	logic [31:0]        since_decay;
	logic [31:0]        since_detent;
	logic [3:0]         count_dec;
	logic [31:0]        last_dec;
	logic signed [1:0]  dir;
	logic [7:0]         step_mag;
	logic signed [15:0] fine_new;
	logic signed [15:0] detent_new;
	logic [3:0]         count_new;
	logic [31:0]        dtime_new;
	logic [31:0]        dtime_prev_new;
	logic signed [15:0] delta;
	logic               up;
	logic [16:0]        mag;
	logic               fast;
	logic signed [17:0] guard_sum;
	logic signed [17:0] lim;
	logic               ovf;
	turn_event_t        ev;

	assign enc_type     = (cfg.encoder_type > TypeMax) ? TypeMax : cfg.encoder_type;
	assign sh           = res_shift(enc_type);
	assign dmask        = detent_mask(enc_type);
	assign pins         = {sig_b, sig_a};
	assign since_decay  = now_ms - cur.last_decay_time;
	assign since_detent = now_ms - cur.detent_time_prev;

	// decay the detent count, or clear it after a long idle gap
	always_comb begin
		count_dec = cur.detent_count;
		last_dec  = cur.last_decay_time;
		if (since_decay > DecayMs && cur.detent_count > 4'd1) begin
			last_dec  = now_ms;
			count_dec = cur.detent_count - 4'd1;
		end else if (since_detent > IdleMs) begin
			last_dec  = now_ms;
			count_dec = 4'd0;
		end
	end

	assign dir      = dir_lookup({cur.prev_pins, pins});
	assign step_mag = ((count_dec > FastAfter) ? SpeedFast : 8'd1) << sh;

	always_comb begin
		fine_new       = cur.fine_position;
		detent_new     = cur.detent_position;
		count_new      = count_dec;
		dtime_new      = cur.detent_time;
		dtime_prev_new = cur.detent_time_prev;
		if (pins != cur.prev_pins) begin
			if (dir > 2'sd0)
				fine_new = cur.fine_position + $signed({8'd0, step_mag});
			else if (dir < 2'sd0)
				fine_new = cur.fine_position - $signed({8'd0, step_mag});
			if (dmask[pins]) begin
				dtime_prev_new = cur.detent_time;
				dtime_new      = now_ms;
				detent_new     = fine_new >>> sh;
				count_new      = (count_dec >= CountCap) ? CountCap : count_dec + 4'd1;
			end
		end
	end

	assign delta     = detent_new - cur.reported_position;
	assign up        = !delta[15];
	assign mag       = up ? {1'b0, delta} : 17'(-$signed({delta[15], delta}));
	assign fast      = mag >= {9'd0, cfg.fast_limit};
	assign guard_sum = $signed({{2{detent_new[15]}}, detent_new})
	                 + $signed({delta[15], delta, 1'b0});
	assign lim       = $signed({3'd0, cfg.max_position});
	assign ovf       = up ? (guard_sum > lim) : (guard_sum < -lim);

	always_comb begin
		nxt                   = cur;
		nxt.prev_pins         = pins;
		nxt.fine_position     = fine_new;
		nxt.detent_position   = detent_new;
		nxt.reported_position = cur.reported_position;
		nxt.detent_count      = count_new;
		nxt.last_decay_time   = last_dec;
		nxt.detent_time       = dtime_new;
		nxt.detent_time_prev  = dtime_prev_new;
		ev                    = EV_NONE;
		if (detent_new != cur.reported_position) begin
			if (fast)
				ev = up ? EV_UP_FAST : EV_DOWN_FAST;
			else
				ev = up ? EV_UP_SLOW : EV_DOWN_SLOW;
			// wrap back to zero before the position runs past the guard
			if (ovf) begin
				nxt.fine_position   = {14'd0, fine_new[1:0]};
				nxt.detent_position = 16'sd0;
			end
			nxt.reported_position = nxt.detent_position;
		end
	end

	always_comb begin
		res.turn_event   = ev;
		res.event_device = (ev != EV_NONE) ? cfg.device_id : 8'd0;
		res.position_out = nxt.detent_position;
	end

endmodule

FILE: sv/quadrature_encoder_accel_decoder_top.sv
// ---------------------------------------------------------------------------
// quadrature_encoder_accel_decoder_top
// Polled quadrature decoder with detent acceleration and turn events.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one poll: sig_a, sig_b (already
//   inverted pin levels) and now_ms. Output channel (out_valid/out_ready)
//   returns exactly one result per poll: turn_event, event_device and the
//   detent position after that poll.
//   The config port writes a register at any edge with cfg_we high; write it
//   only while no poll is in flight.
//   Path: a poll transferred into the input register is evaluated against the
//   decoder state and lands in the result register. Throughput: one poll per
//   cycle while the receiver keeps up, set by the combinational state update
//   between input and result registers.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more poll; in_ready drops only when both are
//   full.
//   Reset clears all positions, the detent count and the timers (detent time
//   starts at 500 ms) and restores the register defaults: encoder type 0,
//   fast limit 50, max position 8000, device id 0.
// ---------------------------------------------------------------------------
module quadrature_encoder_accel_decoder_top
	import qeadec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        sig_a,
	input  logic        sig_b,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  turn_event,
	output logic [7:0]  event_device,
	output logic signed [15:0] position_out
);

	cfg_t        cfg_q;
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	result_t     res;

	logic        valid_s1;
	logic        sig_a_s1;
	logic        sig_b_s1;
	logic [31:0] now_s1;
	logic        valid_s2;
	result_t     res_s2;
	logic        advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.encoder_type <= 3'd0;
			cfg_q.fast_limit   <= 8'd50;
			cfg_q.max_position <= 15'd8000;
			cfg_q.device_id    <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENCODER_TYPE: cfg_q.encoder_type <= cfg_data[2:0];
				CFG_FAST_LIMIT:   cfg_q.fast_limit   <= cfg_data[7:0];
				CFG_MAX_POSITION: cfg_q.max_position <= cfg_data;
				CFG_DEVICE_ID:    cfg_q.device_id    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sig_a_s1 <= sig_a;
			sig_b_s1 <= sig_b;
			now_s1   <= now_ms;
		end
	end

	qeadec_step u_step (
		.cfg    (cfg_q),
		.cur    (state_q),
		.sig_a  (sig_a_s1),
		.sig_b  (sig_b_s1),
		.now_ms (now_s1),
		.nxt    (state_nxt),
		.res    (res)
	);

	// decoder state advances once per evaluated poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.prev_pins         <= 2'd0;
			state_q.fine_position     <= 16'sd0;
			state_q.detent_position   <= 16'sd0;
			state_q.reported_position <= 16'sd0;
			state_q.detent_count      <= 4'd0;
			state_q.last_decay_time   <= 32'd0;
			state_q.detent_time       <= DetentTimeReset;
			state_q.detent_time_prev  <= 32'd0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign turn_event   = res_s2.turn_event;
	assign event_device = res_s2.event_device;
	assign position_out = res_s2.position_out;

	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.detent_count <= CountCap)
		else $error("detent count above cap");

	a_reported_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.reported_position == state_q.detent_position)
		else $error("reported position out of step with detent position");

	a_no_device_without_event: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.turn_event == EV_NONE) |-> (res_s2.event_device == 8'd0))
		else $error("device id sent without an event");

	a_position_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		$past(advance) |-> (res_s2.position_out == state_q.detent_position))
		else $error("result position differs from decoder state");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the quadrature decoder. A short scripted walk through the
// pin transitions, time wrap and register extremes comes first, then random
// rotation gestures with noise polls, under several register setups. Results
// are checked against an in-bench decoder model, or pinned values for typed rows.
// ---------------------------------------------------------------------------
module tb_top
	import qeadec_pkg::*;
;

	localparam logic [31:0] DecaySpanMs = 32'd100;
	localparam logic [31:0] IdleSpanMs  = 32'd500;
	localparam logic [3:0]  CountTop    = 4'd12;
	localparam logic [3:0]  AccelAbove  = 4'd6;
	localparam int          BoostStep   = 51;
	localparam int          HoldCycles  = 80;
	localparam int          MaxPrinted  = 50;

	typedef enum int {RX_STREAM, RX_HALF, RX_LIGHT, RX_HEAVY} rx_mode_e;

	// model state, same meaning as the decoder's registers
	typedef struct packed {
		logic [1:0]         prev_pins;
		logic signed [15:0] fine;
		logic signed [15:0] detent;
		logic signed [15:0] reported;
		logic [3:0]         count;
		logic [31:0]        decay_at;
		logic [31:0]        detent_at;
		logic [31:0]        detent_at_prev;
	} wheel_t;

	typedef struct packed {
		bit                 reconf;
		cfg_t               setup;
		logic               a;
		logic               b;
		logic [31:0]        t;
		bit                 typed;
		turn_event_t        ev;
		logic [7:0]         dev;
		logic signed [15:0] pos;
	} script_row_t;

	typedef struct packed {
		cfg_t setup;
		int   polls;
		int   up_pct;
		int   noise_pct;
		int   max_dt;
		bit   squeeze;
	} phase_t;

	localparam cfg_t NoSetup    = '0;
	localparam cfg_t WildSetup  = '{3'd7, 8'd0, 15'd1, 8'hFF};
	localparam cfg_t TightSetup = '{3'd3, 8'd255, 15'd32767, 8'h5A};

	localparam int ScriptLen = 27;
	localparam script_row_t Script [ScriptLen] = '{
		'{1'b0, NoSetup, 1'b0, 1'b0, 32'd0, 1'b1, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b1, 1'b0, 32'd5, 1'b1, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b1, 1'b1, 32'd10, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b0, 1'b1, 32'd20, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b0, 1'b0, 32'd30, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b0, 1'b1, 32'd40, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b1, 1'b1, 32'd50, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b1, 1'b0, 32'd60, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b0, 1'b0, 32'd70, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b0, 1'b1, 32'd80, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b1, 1'b1, 32'd90, 1'b0, EV_NONE, 8'd0, 16'sd0},
		// skipped states and the time stamp wrapping through zero
		'{1'b0, NoSetup, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b1, 1'b1, 32'h0000_0000, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b1, 1'b1, 32'h0000_0300, 1'b0, EV_NONE, 8'd0, 16'sd0},
		// type beyond the table, every change fast, guard at one
		'{1'b1, WildSetup, 1'b0, 1'b0, 32'd0, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b0, 1'b1, 32'h0000_0310, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b0, 1'b0, 32'h0000_0318, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b0, 1'b1, 32'h0000_0320, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b1, 1'b1, 32'h0000_0328, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b1, 1'b0, 32'h0000_0330, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b1, TightSetup, 1'b0, 1'b0, 32'd0, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b0, 1'b0, 32'h0000_0340, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b0, 1'b1, 32'h0000_0350, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b1, 1'b1, 32'h0000_0360, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b1, 1'b0, 32'h0000_0370, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b0, 1'b0, 32'h8000_0000, 1'b0, EV_NONE, 8'd0, 16'sd0},
		'{1'b0, NoSetup, 1'b1, 1'b0, 32'h8000_0010, 1'b0, EV_NONE, 8'd0, 16'sd0}
	};

	// the long one-way spin drives the fine position through its wrap
	localparam int PhaseCount = 6;
	localparam phase_t Phases [PhaseCount] = '{
		'{'{3'd0, 8'd50, 15'd8000, 8'h3C}, 50, 50, 15, 25, 1'b0},
		'{'{3'd1, 8'd1, 15'd300, 8'h81}, 50, 70, 10, 25, 1'b1},
		'{'{3'd0, 8'd255, 15'd32767, 8'hA5}, 230, 100, 0, 8, 1'b0},
		'{'{3'd2, 8'd8, 15'd0, 8'h5A}, 40, 30, 20, 25, 1'b0},
		'{'{3'd3, 8'd100, 15'd120, 8'hFF}, 40, 50, 20, 25, 1'b0},
		'{'{3'd4, 8'd30, 15'd2000, 8'h00}, 40, 60, 20, 25, 1'b0}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = CFG_ENCODER_TYPE;
	logic [14:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               sig_a = 1'b0;
	logic               sig_b = 1'b0;
	logic [31:0]        now_ms = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         turn_event;
	logic [7:0]         event_device;
	logic signed [15:0] position_out;

	cfg_t     cfg_now;
	wheel_t   wh;
	result_t  turns_due [$];
	logic [1:0]  pins_sent;
	logic [31:0] clock_ms;
	int burst_left;
	int holds_asked;
	int holds_served;
	int err_count;
	int polls_sent;
	int results_seen;
	int turns_seen;
	int fast_seen;
	int guard_hits;
	int input_blocked;
	int setups_used;

	quadrature_encoder_accel_decoder_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sig_a        (sig_a),
		.sig_b        (sig_b),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.turn_event   (turn_event),
		.event_device (event_device),
		.position_out (position_out)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Advance the wheel model by one poll and return the turn it reports.
	function automatic result_t decode_poll(input logic a, input logic b,
			input logic [31:0] t);
		logic [1:0]  pins;
		logic [2:0]  kind;
		logic [1:0]  sh;
		logic [3:0]  mask;
		logic [15:0] diff;
		int dir, step, pos, delta, mag, lim;
		bit up, fast;
		result_t r;
		pins = {b, a};
		kind = (cfg_now.encoder_type > 3'd4) ? 3'd4 : cfg_now.encoder_type;
		case (kind)
			3'd0: begin mask = 4'b1000; sh = 2'd2; end
			3'd1: begin mask = 4'b0001; sh = 2'd2; end
			3'd2: begin mask = 4'b1001; sh = 2'd1; end
			3'd3: begin mask = 4'b0110; sh = 2'd1; end
			default: begin mask = 4'b1111; sh = 2'd0; end
		endcase

		if ((t - wh.decay_at) > DecaySpanMs && wh.count > 4'd1) begin
			wh.decay_at = t;
			wh.count = wh.count - 4'd1;
		end else if ((t - wh.detent_at_prev) > IdleSpanMs) begin
			wh.decay_at = t;
			wh.count = 4'd0;
		end

		if (pins != wh.prev_pins) begin
			case ({wh.prev_pins, pins})
				4'd2, 4'd4, 4'd11, 4'd13: dir = 1;
				4'd1, 4'd7, 4'd8, 4'd14: dir = -1;
				default: dir = 0;
			endcase
			step = dir * ((wh.count > AccelAbove) ? BoostStep : 1) * (1 << sh);
			wh.fine = wh.fine + step[15:0];
			if (mask[pins]) begin
				wh.detent_at_prev = wh.detent_at;
				wh.detent_at = t;
				wh.detent = wh.fine >>> sh;
				wh.count = (wh.count >= CountTop) ? CountTop : wh.count + 4'd1;
			end
			wh.prev_pins = pins;
		end

		r.turn_event = EV_NONE;
		if (wh.detent != wh.reported) begin
			pos = int'(wh.detent);
			diff = wh.detent - wh.reported;
			delta = int'($signed(diff));
			up = delta > 0;
			mag = up ? delta : -delta;
			lim = int'(cfg_now.max_position);
			fast = mag >= int'(cfg_now.fast_limit);
			if (fast)
				r.turn_event = up ? EV_UP_FAST : EV_DOWN_FAST;
			else
				r.turn_event = up ? EV_UP_SLOW : EV_DOWN_SLOW;
			if ((up && pos + 2 * delta > lim) || (!up && pos + 2 * delta < -lim)) begin
				wh.fine = {14'd0, wh.fine[1:0]};
				wh.detent = '0;
				guard_hits++;
			end
			wh.reported = wh.detent;
		end
		r.event_device = (r.turn_event != EV_NONE) ? cfg_now.device_id : 8'd0;
		r.position_out = wh.detent;
		return r;
	endfunction

	task automatic note_fault(input string msg);
		if (err_count < MaxPrinted)
			$display("tb_top: MISMATCH at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	// Offer one poll and hold it until the transfer, then log its turn.
	task automatic send_poll(input logic a, input logic b, input logic [31:0] t,
			input bit typed, input result_t pinned);
		result_t guess;
		in_valid <= 1'b1;
		sig_a <= a;
		sig_b <= b;
		now_ms <= t;
		do @(posedge clk); while (in_ready !== 1'b1);
		guess = decode_poll(a, b, t);
		turns_due.push_back(typed ? pinned : guess);
		polls_sent++;
		pins_sent = {b, a};
		clock_ms = t;
	endtask

	// End a burst now and then with a gap of random length.
	task automatic take_break();
		int gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 32);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (turns_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic apply_setup(input cfg_t c);
		write_reg(CFG_ENCODER_TYPE, {12'd0, c.encoder_type});
		write_reg(CFG_FAST_LIMIT, {7'd0, c.fast_limit});
		write_reg(CFG_MAX_POSITION, c.max_position);
		write_reg(CFG_DEVICE_ID, {7'd0, c.device_id});
		cfg_we <= 1'b0;
		cfg_now = c;
		setups_used++;
	endtask

	// Rotation runs with random length, direction and pace, mixed with noise
	// polls that jump pins or time.
	task automatic run_gestures(input phase_t ph);
		int run_left;
		bit going_up;
		logic [1:0] nxt;
		logic [31:0] t;
		run_left = 0;
		going_up = 1'b1;
		for (int n = 0; n < ph.polls; n++) begin
			t = clock_ms;
			if ($urandom_range(0, 99) < ph.noise_pct) begin
				nxt = 2'($urandom_range(0, 3));
				case ($urandom_range(0, 2))
					0: t = $urandom();
					1: t = t + $urandom_range(501, 3000);
					default: t = t + $urandom_range(101, 499);
				endcase
			end else begin
				if (run_left == 0) begin
					run_left = $urandom_range(4, 40);
					going_up = $urandom_range(0, 99) < ph.up_pct;
				end
				run_left--;
				case (pins_sent)
					2'd0: nxt = going_up ? 2'd2 : 2'd1;
					2'd1: nxt = going_up ? 2'd0 : 2'd3;
					2'd2: nxt = going_up ? 2'd3 : 2'd0;
					default: nxt = going_up ? 2'd1 : 2'd2;
				endcase
				// polled faster than the knob moves
				if (ph.noise_pct != 0 && $urandom_range(0, 9) == 0)
					nxt = pins_sent;
				t = t + $urandom_range(0, ph.max_dt);
			end
			send_poll(nxt[0], nxt[1], t, 1'b0, '0);
			take_break();
		end
	endtask

	// receiver: stall pattern of its own, plus long hold-offs on request
	initial begin
		int hold_left;
		int mode_left;
		rx_mode_e mode;
		hold_left = 0;
		mode_left = 0;
		mode = RX_STREAM;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_served != holds_asked) begin
				holds_served++;
				hold_left = HoldCycles;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_e'($urandom_range(0, 3));
					mode_left = $urandom_range(10, 80);
				end
				mode_left--;
				case (mode)
					RX_STREAM: out_ready <= 1'b1;
					RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
					RX_LIGHT:  out_ready <= ($urandom_range(0, 3) != 0);
					default:   out_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && in_valid && !in_ready)
			input_blocked++;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (turns_due.size() == 0) begin
				note_fault($sformatf("result with nothing due: ev %0d pos %0d",
					turn_event, position_out));
			end else begin
				want = turns_due.pop_front();
				if (turn_event !== want.turn_event)
					note_fault($sformatf("turn_event %0d, want %0d",
						turn_event, want.turn_event));
				if (event_device !== want.event_device)
					note_fault($sformatf("event_device %0d, want %0d",
						event_device, want.event_device));
				if (position_out !== want.position_out)
					note_fault($sformatf("position_out %0d, want %0d",
						position_out, want.position_out));
				results_seen++;
				if (want.turn_event != EV_NONE)
					turns_seen++;
				if (want.turn_event == EV_UP_FAST || want.turn_event == EV_DOWN_FAST)
					fast_seen++;
			end
		end
	end

	initial begin
		result_t pinned;
		cfg_now = '{3'd0, 8'd50, 15'd8000, 8'd0};
		wh = '0;
		wh.detent_at = 32'd500;
		pins_sent = 2'd0;
		clock_ms = '0;
		burst_left = $urandom_range(1, 32);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < ScriptLen; i++) begin
			if (Script[i].reconf) begin
				settle();
				apply_setup(Script[i].setup);
			end else begin
				pinned = '{Script[i].ev, Script[i].dev, Script[i].pos};
				send_poll(Script[i].a, Script[i].b, Script[i].t, Script[i].typed, pinned);
				take_break();
			end
		end

		for (int p = 0; p < PhaseCount; p++) begin
			settle();
			apply_setup(Phases[p].setup);
			if (Phases[p].squeeze)
				holds_asked++;
			run_gestures(Phases[p]);
		end
		settle();

		$display("tb_top: %0d polls over %0d register setups, %0d results checked",
			polls_sent, setups_used, results_seen);
		$display("tb_top: %0d turns (%0d fast), %0d guard resets, input stalled %0d cycles",
			turns_seen, fast_seen, guard_hits, input_blocked);
		if (err_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: %0d mismatches", err_count);
			$display("tb_top: done, errors");
		end
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("tb_top: timeout with %0d results still due", turns_due.size());
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
